@@ design/lru_timestamp_replacement_unit_assert.svh @@
// Assertion macros for the LRU timestamp replacement unit.
`ifndef LRU_TIMESTAMP_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_TIMESTAMP_REPLACEMENT_UNIT_ASSERT_SVH

// Checked outside reset.
`define LRU_TS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define LRU_TS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/lru_ts_pkg.sv @@
`default_nettype none
package lru_ts_pkg;

  localparam int unsigned SETS    = 64;
  localparam int unsigned WAYS    = 16;
  localparam int unsigned STAMP_W = 32;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned SET_W = 6;
  localparam int unsigned WAY_W = 4;

  localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

  localparam int unsigned SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_AW  = $clog2(WAYS);
  localparam int unsigned WAYS_P2 = 1 << WAY_AW;
  localparam int unsigned ROW_W   = WAYS * STAMP_W;
  localparam int unsigned STEP_W  = (WAY_AW > 1) ? $clog2(WAY_AW) : 1;

  typedef struct packed {
    logic latch;     // capture request and read its row
    logic clr;       // write a zero row at the clear pointer
    logic write;     // stamp the latched way and bump the counter
    logic load;      // load the min tree from the row just read
    logic reduce;    // one tree level
    logic out_load;  // move the winner to the output register
  } lru_ts_cmd_t;

  typedef struct packed {
    logic clr_last;
  } lru_ts_sts_t;

endpackage
`default_nettype wire

@@ design/lru_ts_ram.sv @@
`default_nettype none
module lru_ts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ design/lru_ts_ctrl.sv @@
`default_nettype none
module lru_ts_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [lru_ts_pkg::CMD_W-1:0] command_i,
  input  wire logic [lru_ts_pkg::SET_W-1:0] set_index_i,
  input  wire logic [lru_ts_pkg::WAY_W-1:0] way_i,
  input  wire logic                        hit_i,
  input  wire logic                        is_writeback_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  input  wire lru_ts_pkg::lru_ts_sts_t     sts_i,
  output lru_ts_pkg::lru_ts_cmd_t          cmd_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_STAMP  = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_REDUCE = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0] state_q, state_d;
  logic [lru_ts_pkg::STEP_W-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  logic accept, set_ok, way_ok, do_victim, do_stamp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign set_ok     = 32'(set_index_i) < lru_ts_pkg::SETS;
  assign way_ok     = 32'(way_i) < lru_ts_pkg::WAYS;
  assign do_victim  = set_ok && (command_i == lru_ts_pkg::CMD_VICTIM);
  assign do_stamp   = set_ok && way_ok &&
                      ((command_i == lru_ts_pkg::CMD_FILL) ||
                       ((command_i == lru_ts_pkg::CMD_UPDATE) && hit_i && !is_writeback_i));

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && do_victim) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_LOAD;
        end else if (accept && do_stamp) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_STAMP;
        end
      end
      ST_STAMP: begin
        cmd_o.write = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        step_d     = '0;
        state_d    = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd_o.reduce = 1'b1;
        step_d       = step_q + 1'b1;
        if (step_q == lru_ts_pkg::STEP_W'(lru_ts_pkg::WAY_AW - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait until the previous result has left the output register
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ design/lru_ts_dp.sv @@
`default_nettype none
module lru_ts_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lru_ts_pkg::lru_ts_cmd_t     cmd_i,
  output lru_ts_pkg::lru_ts_sts_t          sts_o,
  input  wire logic [lru_ts_pkg::SET_W-1:0] set_index_i,
  input  wire logic [lru_ts_pkg::WAY_W-1:0] way_i,
  output logic      [lru_ts_pkg::WAY_W-1:0] victim_way_o
);

  localparam int unsigned HALF = lru_ts_pkg::WAYS_P2 / 2;

  logic [lru_ts_pkg::SET_AW-1:0]  set_q, clr_cnt_q, ram_addr;
  logic [lru_ts_pkg::WAY_AW-1:0]  way_q;
  logic [lru_ts_pkg::STAMP_W-1:0] counter_q;
  logic [lru_ts_pkg::WAY_W-1:0]   victim_q;
  logic [lru_ts_pkg::ROW_W-1:0]   rdata, wdata, row_upd;
  logic                           ram_we;

  logic [lru_ts_pkg::STAMP_W-1:0] cand_stamp_q [lru_ts_pkg::WAYS_P2];
  logic [lru_ts_pkg::WAY_AW-1:0]  cand_idx_q   [lru_ts_pkg::WAYS_P2];

  always_comb begin
    row_upd = rdata;
    row_upd[way_q * lru_ts_pkg::STAMP_W +: lru_ts_pkg::STAMP_W] = counter_q;
  end

  assign ram_we = cmd_i.clr || cmd_i.write;
  assign wdata  = cmd_i.clr ? '0 : row_upd;

  always_comb begin
    priority if (cmd_i.clr) begin
      ram_addr = clr_cnt_q;
    end else if (cmd_i.write) begin
      ram_addr = set_q;
    end else begin
      ram_addr = lru_ts_pkg::SET_AW'(set_index_i);
    end
  end

  lru_ts_ram #(
    .WIDTH (lru_ts_pkg::ROW_W),
    .DEPTH (lru_ts_pkg::SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.latch),
    .addr_i  (ram_addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign sts_o.clr_last = (clr_cnt_q == lru_ts_pkg::SET_AW'(lru_ts_pkg::SETS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      counter_q <= '0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.write) begin
        counter_q <= counter_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      set_q <= lru_ts_pkg::SET_AW'(set_index_i);
      way_q <= lru_ts_pkg::WAY_AW'(way_i);
    end
    if (cmd_i.out_load) begin
      victim_q <= lru_ts_pkg::WAY_W'(cand_idx_q[0]);
    end
  end

  // Min tree: one level per cycle, the left (lower) way wins ties.
  // Padding slots hold all ones so a real way always beats them.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < lru_ts_pkg::WAYS_P2; i++) begin
        cand_idx_q[i] <= lru_ts_pkg::WAY_AW'(i);
        if (i < lru_ts_pkg::WAYS) begin
          cand_stamp_q[i] <= rdata[i * lru_ts_pkg::STAMP_W +: lru_ts_pkg::STAMP_W];
        end else begin
          cand_stamp_q[i] <= '1;
        end
      end
    end else if (cmd_i.reduce) begin
      for (int i = 0; i < HALF; i++) begin
        if (cand_stamp_q[2*i+1] < cand_stamp_q[2*i]) begin
          cand_stamp_q[i] <= cand_stamp_q[2*i+1];
          cand_idx_q[i]   <= cand_idx_q[2*i+1];
        end else begin
          cand_stamp_q[i] <= cand_stamp_q[2*i];
          cand_idx_q[i]   <= cand_idx_q[2*i];
        end
      end
    end
  end

  assign victim_way_o = victim_q;

endmodule
`default_nettype wire

@@ design/lru_timestamp_replacement_unit.sv @@
// LRU replacement by last-use timestamps, one 32-bit stamp per set and way.
// Request channel: in_valid_i / in_stall_o with command_i, set_index_i, way_i,
// hit_i and is_writeback_i; a request is taken when valid is high and stall low.
// Result channel: out_valid_o / out_stall_i with victim_way_o, one result per
// find-victim request, none for fills, updates or ignored requests.
// Sequencing: a fill or counted update reads its row, then writes the row
// back with the new stamp. A find-victim request goes through row read,
// tree load, tree reduction level by level and output load; the result is
// registered at output load. Requests that change nothing leave the unit
// idle. The single-port row memory and the shared min tree serialize
// requests, one at a time.
// Reset: the counter clears, then a clearing pass zeroes the stamp memory,
// one set per cycle, with in_stall_o high. A stalled result holds in the
// output register; the next request is still taken, and a following
// find-victim waits in its last step until the register frees up.
`default_nettype none
module lru_timestamp_replacement_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [lru_ts_pkg::CMD_W-1:0] command_i,
  input  wire logic [lru_ts_pkg::SET_W-1:0] set_index_i,
  input  wire logic [lru_ts_pkg::WAY_W-1:0] way_i,
  input  wire logic                        hit_i,
  input  wire logic                        is_writeback_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [lru_ts_pkg::WAY_W-1:0] victim_way_o
);

  lru_ts_pkg::lru_ts_cmd_t cmd;
  lru_ts_pkg::lru_ts_sts_t sts;

  lru_ts_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .set_index_i    (set_index_i),
    .way_i          (way_i),
    .hit_i          (hit_i),
    .is_writeback_i (is_writeback_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  lru_ts_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .set_index_i  (set_index_i),
    .way_i        (way_i),
    .victim_way_o (victim_way_o)
  );

endmodule
`default_nettype wire

@@ design/lru_ts_checker.sv @@
`default_nettype none
`include "lru_timestamp_replacement_unit_assert.svh"
module lru_ts_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic [lru_ts_pkg::CMD_W-1:0] command_i,
  input wire logic [lru_ts_pkg::SET_W-1:0] set_index_i,
  input wire logic [lru_ts_pkg::WAY_W-1:0] way_i,
  input wire logic                        hit_i,
  input wire logic                        is_writeback_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [lru_ts_pkg::WAY_W-1:0] victim_way_o
);

  logic victim_req, fill_req;

  assign victim_req = in_valid_i && !in_stall_o &&
                      (command_i == lru_ts_pkg::CMD_VICTIM) &&
                      (32'(set_index_i) < lru_ts_pkg::SETS);
  assign fill_req   = in_valid_i && !in_stall_o &&
                      (command_i == lru_ts_pkg::CMD_FILL) &&
                      (32'(set_index_i) < lru_ts_pkg::SETS) &&
                      (32'(way_i) < lru_ts_pkg::WAYS) && (hit_i || !hit_i) &&
                      (is_writeback_i || !is_writeback_i);

  `LRU_TS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(victim_way_o), "stalled result changed")
  `LRU_TS_ASSERT(a_victim_busy, victim_req |=> in_stall_o, "find-victim request did not occupy the unit")
  `LRU_TS_ASSERT(a_fill_two, fill_req |=> in_stall_o ##1 !in_stall_o, "fill did not take two cycles")
  `LRU_TS_ASSERT_ALWAYS(a_clear_pass, $rose(rst_ni) |-> in_stall_o, "requests taken during clearing pass")

endmodule

bind lru_timestamp_replacement_unit lru_ts_checker u_lru_ts_checker (.*);
`default_nettype wire
